FILE: src/erl_pkg.sv
package erl_pkg;

  // Grid and field widths
  localparam int GRID_SIDE   = 16;
  localparam int COORD_W     = 4;
  localparam int COLOR_W     = 8;
  localparam int INDEX_W     = 8;
  localparam int DIST_W      = 14;
  localparam int RADIUS_W    = 14;
  localparam int THICK_W     = 12;
  localparam int GROWTH_W    = 10;
  localparam int INTENS_W    = 8;
  localparam int MODE_W      = 8;
  localparam int FRAME_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int FADE_W      = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ROM_DEPTH   = 1 << (2 * COORD_W);

  // Animation constants
  localparam int FADE_FRAMES = 30;
  localparam int FADE_NUM    = 225;
  localparam int FULL_SCALE  = 255;
  localparam int PURPLE_RED  = 180;
  localparam int PURPLE_BLUE = 200;
  localparam logic signed [RADIUS_W-1:0] RADIUS_START  = 14'sd128;
  localparam logic signed [RADIUS_W-1:0] RADIUS_TOP    = 14'sd1792;
  localparam logic signed [RADIUS_W-1:0] RADIUS_BOTTOM = 14'sd128;
  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

  // Item function codes
  localparam logic FUNC_PIXEL   = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THICKNESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_SEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_FRAMES = 3'd4;

  // Register reset values
  localparam logic [THICK_W-1:0]  THICK_RESET     = 12'd256;
  localparam logic [GROWTH_W-1:0] GROWTH_RESET    = 10'd64;
  localparam logic [INTENS_W-1:0] INTENS_RESET    = 8'd255;
  localparam logic [MODE_W-1:0]   MODE_RESET      = 8'd0;
  localparam logic [FRAME_W-1:0]  RUN_FRAMES_RESET = 16'd60;

  // Color modes after reduction modulo 3
  localparam logic [1:0] MODE_BLUE   = 2'd0;
  localparam logic [1:0] MODE_RED    = 2'd1;

  typedef enum logic {
    PH_RUN,
    PH_FADE
  } phase_t;

  typedef struct packed {
    logic [THICK_W-1:0]  thickness;
    logic [GROWTH_W-1:0] growth;
    logic [GAIN_W-1:0]   red_gain;
    logic [GAIN_W-1:0]   blue_gain;
    logic [FRAME_W-1:0]  run_frames;
  } cfg_t;

  typedef struct packed {
    logic signed [RADIUS_W-1:0] radius;
    logic                       fading;
    logic                       done;
  } anim_t;

  typedef logic [ROM_DEPTH-1:0][DIST_W-1:0] dist_rom_t;

  // floor(y / 255) for y up to 65279
  function automatic logic [COLOR_W-1:0] div255(input logic [15:0] y);
    logic [16:0] s;
    s = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [COLOR_W-1:0] dim_channel(input logic [COLOR_W-1:0] c);
    logic [15:0] p;
    p = {8'd0, c} * 16'(FADE_NUM);
    return div255(p);
  endfunction

  // Base-4 digit sum, then one fold and one conditional subtract
  function automatic logic [1:0] mod3(input logic [MODE_W-1:0] m);
    logic [3:0] s;
    logic [2:0] t;
    s = {2'b0, m[7:6]} + {2'b0, m[5:4]} + {2'b0, m[3:2]} + {2'b0, m[1:0]};
    t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // Q4.8 distance from the grid center, rounded to nearest
  function automatic logic [DIST_W-1:0] centre_dist(input int col, input int row);
    int          a;
    int          b;
    int unsigned n;
    int unsigned root;
    int unsigned bitv;
    a = 2 * col - (GRID_SIDE - 1);
    b = 2 * row - (GRID_SIDE - 1);
    n = (a * a + b * b) * 65536;
    root = 0;
    for (int i = 0; i < 16; i++) begin
      bitv = 32'd1 << (30 - 2 * i);
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
    end
    return DIST_W'((root + 1) >> 1);
  endfunction

  function automatic dist_rom_t build_dist_rom();
    dist_rom_t rom;
    for (int c = 0; c < (1 << COORD_W); c++) begin
      for (int r = 0; r < (1 << COORD_W); r++) begin
        rom[c * (1 << COORD_W) + r] = centre_dist(c, r);
      end
    end
    return rom;
  endfunction

  localparam dist_rom_t DIST_ROM = build_dist_rom();

endpackage

FILE: src/expanding_ring_led_effect.sv
// An accepted beat is held in the input register, and its result then in the result register.
// Throughput: one pixel beat per cycle while out_stall stays low; restart beats yield no result.
// The rate is set by the single compute pass between the input and result registers.
// Reset (rst, synchronous, active high) clears the pipeline valids, restores all
// registers to their defaults and returns the animation to radius 0.5, growing, run phase.
module expanding_ring_led_effect (
  input  logic                           clk,
  input  logic                           rst,
  // pixel input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [erl_pkg::COORD_W-1:0]    column,
  input  logic [erl_pkg::COORD_W-1:0]    row,
  input  logic [erl_pkg::COLOR_W-1:0]    old_red,
  input  logic [erl_pkg::COLOR_W-1:0]    old_green,
  input  logic [erl_pkg::COLOR_W-1:0]    old_blue,
  input  logic                           frame_end,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [erl_pkg::INDEX_W-1:0]    led_index,
  output logic [erl_pkg::COLOR_W-1:0]    new_red,
  output logic [erl_pkg::COLOR_W-1:0]    new_green,
  output logic [erl_pkg::COLOR_W-1:0]    new_blue,
  output logic                           last_of_frame,
  output logic                           anim_done,
  // register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [erl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import erl_pkg::*;

  // Input register stage
  logic               s1_valid;
  logic               s1_func;
  logic [COORD_W-1:0] s1_column;
  logic [COORD_W-1:0] s1_row;
  logic [COLOR_W-1:0] s1_red;
  logic [COLOR_W-1:0] s1_green;
  logic [COLOR_W-1:0] s1_blue;
  logic               s1_fend;

  logic               s1_adv;
  logic               step;
  logic               restart;

  cfg_t               cfg;
  anim_t              anim;
  logic [INDEX_W-1:0] px_index;
  logic [COLOR_W-1:0] px_red;
  logic [COLOR_W-1:0] px_green;
  logic [COLOR_W-1:0] px_blue;

  // The input stage moves on whenever the result register is empty or being drained;
  // a waiting result blocks the input only once the input stage also holds a beat.
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;

  // Animation state advances with the beat leaving the input stage, which keeps
  // state updates in beat order.
  assign step    = s1_valid && s1_adv && (s1_func == FUNC_PIXEL);
  assign restart = s1_valid && s1_adv && (s1_func == FUNC_RESTART);

  erl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  erl_anim u_anim (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .restart    (restart),
    .frame_end  (s1_fend),
    .growth     (cfg.growth),
    .run_frames (cfg.run_frames),
    .anim       (anim)
  );

  erl_pixel u_pixel (
    .column    (s1_column),
    .row       (s1_row),
    .old_red   (s1_red),
    .old_green (s1_green),
    .old_blue  (s1_blue),
    .cfg       (cfg),
    .anim      (anim),
    .led_index (px_index),
    .red       (px_red),
    .green     (px_green),
    .blue      (px_blue)
  );

  // Capture a new beat whenever the input stage is free to take one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_func   <= func;
      s1_column <= column;
      s1_row    <= row;
      s1_red    <= old_red;
      s1_green  <= old_green;
      s1_blue   <= old_blue;
      s1_fend   <= frame_end;
    end
  end

  // Result register: load pixel results, drop restart beats
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      led_index     <= px_index;
      new_red       <= px_red;
      new_green     <= px_green;
      new_blue      <= px_blue;
      last_of_frame <= s1_fend;
      anim_done     <= anim.done;
    end
  end

  // A restart beat leaving the input stage leaves the result register empty
  assert property (@(posedge clk) disable iff (rst)
    restart |=> !out_valid)
    else $error("restart beat produced a result");

  // A pixel beat leaving the input stage always lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("pixel beat lost");

  // Completion is flagged only on the last pixel of a frame
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && anim_done) |-> last_of_frame)
    else $error("anim_done without frame end");

  // Backpressure reaches the input only through a full input stage
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");

endmodule

FILE: src/erl_cfg.sv
module erl_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [erl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erl_pkg::CFG_DATA_W-1:0] cfg_data,
  output erl_pkg::cfg_t                  cfg
);
  import erl_pkg::*;

  logic [THICK_W-1:0]  thickness;
  logic [GROWTH_W-1:0] growth;
  logic [INTENS_W-1:0] intensity;
  logic [MODE_W-1:0]   hue_sel;
  logic [FRAME_W-1:0]  run_frames;
  logic [GAIN_W-1:0]   red_gain;
  logic [GAIN_W-1:0]   blue_gain;

  logic                wr;
  logic [INTENS_W-1:0] intensity_next;
  logic [MODE_W-1:0]   hue_sel_next;
  logic [1:0]          mode3;
  logic [GAIN_W-1:0]   red_gain_next;
  logic [GAIN_W-1:0]   blue_gain_next;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_comb begin
    intensity_next = intensity;
    hue_sel_next   = hue_sel;
    if (wr && cfg_index == REG_INTENSITY) begin
      intensity_next = cfg_data[INTENS_W-1:0];
    end
    if (wr && cfg_index == REG_HUE_SEL) begin
      hue_sel_next = cfg_data[MODE_W-1:0];
    end
  end

  // Fold intensity and color scale into one gain for red and one for blue at write time
  always_comb begin
    mode3 = mod3(hue_sel_next);
    case (mode3)
      MODE_BLUE: begin
        red_gain_next  = '0;
        blue_gain_next = {8'd0, intensity_next} * 16'(FULL_SCALE);
      end
      MODE_RED: begin
        red_gain_next  = {8'd0, intensity_next} * 16'(FULL_SCALE);
        blue_gain_next = '0;
      end
      default: begin
        red_gain_next  = {8'd0, intensity_next} * 16'(PURPLE_RED);
        blue_gain_next = {8'd0, intensity_next} * 16'(PURPLE_BLUE);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thickness  <= THICK_RESET;
      growth     <= GROWTH_RESET;
      intensity  <= INTENS_RESET;
      hue_sel    <= MODE_RESET;
      run_frames <= RUN_FRAMES_RESET;
      red_gain   <= '0;
      blue_gain  <= {8'd0, INTENS_RESET} * 16'(FULL_SCALE);
    end else if (wr) begin
      case (cfg_index)
        REG_THICKNESS:  thickness  <= cfg_data[THICK_W-1:0];
        REG_GROWTH:     growth     <= cfg_data[GROWTH_W-1:0];
        REG_RUN_FRAMES: run_frames <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
      intensity  <= intensity_next;
      hue_sel    <= hue_sel_next;
      red_gain   <= red_gain_next;
      blue_gain  <= blue_gain_next;
    end
  end

  assign cfg.thickness  = thickness;
  assign cfg.growth     = growth;
  assign cfg.red_gain   = red_gain;
  assign cfg.blue_gain  = blue_gain;
  assign cfg.run_frames = run_frames;

endmodule

FILE: src/erl_anim.sv
module erl_anim (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        restart,
  input  logic                        frame_end,
  input  logic [erl_pkg::GROWTH_W-1:0] growth,
  input  logic [erl_pkg::FRAME_W-1:0]  run_frames,
  output erl_pkg::anim_t              anim
);
  import erl_pkg::*;

  phase_t                     phase;
  phase_t                     phase_next;
  logic signed [RADIUS_W-1:0] radius;
  logic signed [RADIUS_W-1:0] radius_next;
  logic                       growing;
  logic                       growing_next;
  logic [FRAME_W-1:0]         frame_count;
  logic [FRAME_W-1:0]         frame_count_next;

  logic signed [RADIUS_W:0]   rad_sum;
  logic signed [RADIUS_W:0]   step_ext;
  logic [FRAME_W:0]           run_count;
  logic [FRAME_W-1:0]         fade_count;
  logic                       frame_tick;
  logic                       run_over;

  assign frame_tick = step && frame_end;
  assign step_ext   = $signed({5'd0, growth});
  assign rad_sum    = growing ? ({radius[RADIUS_W-1], radius} + step_ext)
                              : ({radius[RADIUS_W-1], radius} - step_ext);
  assign run_count  = {1'b0, frame_count} + 17'd1;
  assign run_over   = run_count >= {1'b0, run_frames};
  assign fade_count = (frame_count == FRAME_MAX) ? frame_count : frame_count + 16'd1;

  // Phase transitions
  always_comb begin
    phase_next = phase;
    if (restart) begin
      phase_next = PH_RUN;
    end else if (frame_tick) begin
      case (phase)
        PH_RUN:  if (run_over) phase_next = PH_FADE;
        PH_FADE: phase_next = PH_FADE;
        default: phase_next = PH_RUN;
      endcase
    end
  end

  // Radius, direction and frame count
  always_comb begin
    radius_next      = radius;
    growing_next     = growing;
    frame_count_next = frame_count;
    if (restart) begin
      radius_next      = RADIUS_START;
      growing_next     = 1'b1;
      frame_count_next = '0;
    end else if (frame_tick) begin
      if (phase == PH_FADE) begin
        frame_count_next = fade_count;
      end else begin
        radius_next = rad_sum[RADIUS_W-1:0];
        if (rad_sum >= RADIUS_TOP) begin
          growing_next = 1'b0;
        end
        if (rad_sum <= RADIUS_BOTTOM && !growing_next) begin
          growing_next = 1'b1;
        end
        frame_count_next = run_over ? '0 : run_count[FRAME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_RUN;
      radius      <= RADIUS_START;
      growing     <= 1'b1;
      frame_count <= '0;
    end else begin
      phase       <= phase_next;
      radius      <= radius_next;
      growing     <= growing_next;
      frame_count <= frame_count_next;
    end
  end

  // Outputs seen by the pixel in flight
  always_comb begin
    anim.radius = radius;
    anim.fading = (phase == PH_FADE);
    anim.done   = (phase == PH_FADE) && frame_end && (fade_count >= 16'(FADE_FRAMES));
  end

endmodule

FILE: src/erl_pixel.sv
module erl_pixel (
  input  logic [erl_pkg::COORD_W-1:0] column,
  input  logic [erl_pkg::COORD_W-1:0] row,
  input  logic [erl_pkg::COLOR_W-1:0] old_red,
  input  logic [erl_pkg::COLOR_W-1:0] old_green,
  input  logic [erl_pkg::COLOR_W-1:0] old_blue,
  input  erl_pkg::cfg_t               cfg,
  input  erl_pkg::anim_t              anim,
  output logic [erl_pkg::INDEX_W-1:0] led_index,
  output logic [erl_pkg::COLOR_W-1:0] red,
  output logic [erl_pkg::COLOR_W-1:0] green,
  output logic [erl_pkg::COLOR_W-1:0] blue
);
  import erl_pkg::*;

  logic [DIST_W-1:0]  ctr_dist;
  logic signed [15:0] diff;
  logic [15:0]        adiff;
  logic               in_ring;
  logic [FADE_W-1:0]  fade;
  logic [24:0]        red_prod;
  logic [24:0]        blue_prod;
  logic [INDEX_W-1:0] row_base;
  logic [INDEX_W-1:0] col_pos;

  assign ctr_dist = DIST_ROM[{column, row}];
  assign diff = $signed({2'b0, ctr_dist})
              - $signed({{2{anim.radius[RADIUS_W-1]}}, anim.radius});
  assign adiff = diff[15] ? 16'(-diff) : 16'(diff);
  assign in_ring = !anim.fading && (adiff < {4'd0, cfg.thickness});
  assign fade = (adiff >= 16'd256) ? '0 : FADE_W'(16'd256 - adiff);

  assign red_prod  = {16'd0, fade} * {9'd0, cfg.red_gain};
  assign blue_prod = {16'd0, fade} * {9'd0, cfg.blue_gain};

  always_comb begin
    if (in_ring) begin
      red   = div255(red_prod[23:8]);
      green = '0;
      blue  = div255(blue_prod[23:8]);
    end else begin
      red   = dim_channel(old_red);
      green = dim_channel(old_green);
      blue  = dim_channel(old_blue);
    end
  end

  // Serpentine: odd rows run right to left
  assign row_base  = INDEX_W'({4'd0, row} * 8'(GRID_SIDE));
  assign col_pos   = row[0] ? (8'(GRID_SIDE - 1) - {4'd0, column}) : {4'd0, column};
  assign led_index = row_base + col_pos;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import erl_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int BEATS_PER_PHASE = 200;
  localparam int POST_DRAIN      = 6;      // margin for the pipeline to clear
  localparam int HOLD_CYCLES     = 250;    // long output hold-off, fills the pipeline
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_PRINTED     = 40;
  localparam int RING_DIV        = 256 * FULL_SCALE;
  localparam int N_FIXED         = 6;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               frame_end;
  } pixel_beat_t;

  typedef struct packed {
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
    logic               done;
  } led_result_t;

  // pinned rows carry a hand-written result; the others are predicted
  typedef struct packed {
    logic        pinned;
    pixel_beat_t beat;
    led_result_t want;
  } directed_row_t;

  typedef struct packed {
    logic [THICK_W-1:0]  thickness;
    logic [GROWTH_W-1:0] growth;
    logic [INTENS_W-1:0] intensity;
    logic [MODE_W-1:0]   mode;
    logic [FRAME_W-1:0]  run_frames;
  } ring_setting_t;

  // DUT-facing signals; the inputs that the bench drives are known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  func = FUNC_PIXEL;
  logic [COORD_W-1:0]    column = '0;
  logic [COORD_W-1:0]    row = '0;
  logic [COLOR_W-1:0]    old_red = '0;
  logic [COLOR_W-1:0]    old_green = '0;
  logic [COLOR_W-1:0]    old_blue = '0;
  logic                  frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [INDEX_W-1:0]    led_index;
  logic [COLOR_W-1:0]    new_red;
  logic [COLOR_W-1:0]    new_green;
  logic [COLOR_W-1:0]    new_blue;
  logic                  last_of_frame;
  logic                  anim_done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  expanding_ring_led_effect u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .column        (column),
    .row           (row),
    .old_red       (old_red),
    .old_green     (old_green),
    .old_blue      (old_blue),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .led_index     (led_index),
    .new_red       (new_red),
    .new_green     (new_green),
    .new_blue      (new_blue),
    .last_of_frame (last_of_frame),
    .anim_done     (anim_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: register file and animation state
  // ---------------------------------------------------------------------------
  logic [THICK_W-1:0]  thick_cfg     = THICK_RESET;
  logic [GROWTH_W-1:0] growth_cfg    = GROWTH_RESET;
  logic [INTENS_W-1:0] intensity_cfg = INTENS_RESET;
  logic [MODE_W-1:0]   mode_cfg      = MODE_RESET;
  logic [FRAME_W-1:0]  run_cfg       = RUN_FRAMES_RESET;

  int     ring_radius;     // Q5.8, signed
  bit     ring_growing;
  phase_t anim_phase;
  int     frames_in_phase;

  led_result_t led_expect_q[$];

  // bookkeeping for the closing summary
  int pixel_beats   = 0;
  int restart_beats = 0;
  int reg_writes    = 0;
  int settings_used = 0;
  int ring_hits     = 0;
  int results_seen  = 0;
  int done_seen     = 0;
  int mismatches    = 0;

  int  burst_left      = 0;
  bit  hold_off_request = 1'b0;

  function automatic void restart_animation();
    ring_radius     = int'(RADIUS_START);
    ring_growing    = 1'b1;
    anim_phase      = PH_RUN;
    frames_in_phase = 0;
  endfunction

  initial restart_animation();

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_THICKNESS:  thick_cfg     = val[THICK_W-1:0];
      REG_GROWTH:     growth_cfg    = val[GROWTH_W-1:0];
      REG_INTENSITY:  intensity_cfg = val[INTENS_W-1:0];
      REG_HUE_SEL:    mode_cfg      = val[MODE_W-1:0];
      REG_RUN_FRAMES: run_cfg       = val[FRAME_W-1:0];
      default: ;
    endcase
  endfunction

  // Distance from the grid center in Q4.8, rounded to nearest. Work in
  // half-pixel units (2*col - (S-1)) so the center lands on an integer, take
  // floor(sqrt) of the square scaled by 2^16 by bisection, then halve with
  // rounding.
  function automatic int center_distance_q8(input int col, input int rw);
    longint a;
    longint b;
    longint target;
    longint lo;
    longint hi;
    longint mid;
    a = 2 * col - (GRID_SIDE - 1);
    b = 2 * rw - (GRID_SIDE - 1);
    target = (a * a + b * b) * 65536;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= target) lo = mid;
      else hi = mid - 1;
    end
    return int'((lo + 1) >> 1);
  endfunction

  function automatic int ring_level(input int fade, input int scale);
    return (fade * int'(intensity_cfg) * scale) / RING_DIV;
  endfunction

  // Work out what one accepted beat does to the state and what it emits.
  task automatic predict_led_beat(input pixel_beat_t bt, output bit emits,
                                  output led_result_t res);
    int         diff;
    int         gap;
    int         fade;
    int         r;
    int         g;
    int         b;
    int         idx;
    logic [1:0] hue;
    bit         done;
    emits = 1'b0;
    res   = '0;
    if (bt.func == FUNC_RESTART) begin
      restart_animation();
    end else begin
      emits = 1'b1;
      done  = 1'b0;
      r = (int'(bt.red)   * FADE_NUM) / FULL_SCALE;
      g = (int'(bt.green) * FADE_NUM) / FULL_SCALE;
      b = (int'(bt.blue)  * FADE_NUM) / FULL_SCALE;
      // ring overrides the dimmed color only while the animation runs
      if (anim_phase == PH_RUN) begin
        diff = center_distance_q8(int'(bt.column), int'(bt.row)) - ring_radius;
        gap  = (diff < 0) ? -diff : diff;
        if (gap < int'(thick_cfg)) begin
          ring_hits++;
          fade = (gap >= 256) ? 0 : 256 - gap;   // wide ring edge goes black
          hue  = 2'(int'(mode_cfg) % 3);
          r = 0;
          g = 0;
          b = 0;
          case (hue)
            MODE_BLUE: b = ring_level(fade, FULL_SCALE);
            MODE_RED:  r = ring_level(fade, FULL_SCALE);
            default: begin
              r = ring_level(fade, PURPLE_RED);
              b = ring_level(fade, PURPLE_BLUE);
            end
          endcase
        end
      end
      // serpentine wiring: odd rows run right to left
      if (bt.row[0]) idx = int'(bt.row) * GRID_SIDE + (GRID_SIDE - 1) - int'(bt.column);
      else           idx = int'(bt.row) * GRID_SIDE + int'(bt.column);
      // frame end moves the animation on, after this pixel's color is fixed
      if (bt.frame_end) begin
        if (anim_phase == PH_FADE) begin
          if (frames_in_phase < int'(FRAME_MAX)) frames_in_phase++;
          done = (frames_in_phase >= FADE_FRAMES);
        end else begin
          if (ring_growing) ring_radius = ring_radius + int'(growth_cfg);
          else              ring_radius = ring_radius - int'(growth_cfg);
          if (ring_radius >= int'(RADIUS_TOP)) ring_growing = 1'b0;
          if (ring_radius <= int'(RADIUS_BOTTOM) && !ring_growing) ring_growing = 1'b1;
          frames_in_phase++;
          if (frames_in_phase >= int'(run_cfg)) begin
            anim_phase      = PH_FADE;
            frames_in_phase = 0;
          end
        end
      end
      res.led_index = INDEX_W'(idx);
      res.red       = COLOR_W'(r);
      res.green     = COLOR_W'(g);
      res.blue      = COLOR_W'(b);
      res.last      = bt.frame_end;
      res.done      = done;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: bursts of back-to-back beats separated by idle gaps
  // ---------------------------------------------------------------------------
  task automatic send_beat(input pixel_beat_t bt, input bit pinned, input led_result_t want);
    bit          emits;
    led_result_t res;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    func      <= bt.func;
    column    <= bt.column;
    row       <= bt.row;
    old_red   <= bt.red;
    old_green <= bt.green;
    old_blue  <= bt.blue;
    frame_end <= bt.frame_end;
    // hold the beat until the block takes it
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    predict_led_beat(bt, emits, res);
    if (bt.func == FUNC_RESTART) restart_beats++;
    else pixel_beats++;
    if (emits) led_expect_q.push_back(pinned ? want : res);
  endtask

  // Drop valid and wait until every expected beat has come out, plus a margin
  // so a trailing restart beat has also cleared the pipeline.
  task automatic settle_pipeline();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (POST_DRAIN) @(posedge clk);
  endtask

  task automatic program_regs(input ring_setting_t s);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{REG_THICKNESS, REG_GROWTH, REG_INTENSITY, REG_HUE_SEL, REG_RUN_FRAMES};
    val = '{CFG_DATA_W'(s.thickness), CFG_DATA_W'(s.growth), CFG_DATA_W'(s.intensity),
            CFG_DATA_W'(s.mode), CFG_DATA_W'(s.run_frames)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg_write(idx[i], val[i]);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [COLOR_W-1:0] random_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // A stray frame end now and then acts as noise inside a frame.
  function automatic pixel_beat_t random_pixel(input bit closes_frame);
    pixel_beat_t bt;
    bt.func      = FUNC_PIXEL;
    bt.column    = COORD_W'($urandom_range(0, 15));
    bt.row       = COORD_W'($urandom_range(0, 15));
    bt.red       = random_channel();
    bt.green     = random_channel();
    bt.blue      = random_channel();
    bt.frame_end = closes_frame || ($urandom_range(0, 49) == 0);
    return bt;
  endfunction

  function automatic ring_setting_t random_setting();
    ring_setting_t s;
    s.thickness  = THICK_W'($urandom_range(0, 4095));
    s.growth     = GROWTH_W'($urandom_range(0, 1023));
    s.intensity  = INTENS_W'($urandom_range(0, 255));
    s.mode       = MODE_W'($urandom_range(0, 255));
    s.run_frames = ($urandom_range(0, 1) == 0) ? FRAME_W'($urandom_range(0, 6))
                                               : FRAME_W'($urandom_range(0, 65535));
    return s;
  endfunction

  // Well-formed frames of random length and content; rare restarts and rare
  // full drains mixed in.
  task automatic random_frames(input int n_beats);
    pixel_beat_t bt;
    int          sent;
    int          frame_len;
    sent = 0;
    while (sent < n_beats) begin
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 8);
      for (int k = 0; k < frame_len; k++) begin
        if ($urandom_range(0, 399) == 0) begin
          bt      = random_pixel(1'($urandom_range(0, 1)));
          bt.func = FUNC_RESTART;
          send_beat(bt, 1'b0, '0);
        end
        bt = random_pixel(k == frame_len - 1);
        send_beat(bt, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 99) == 0) settle_pipeline();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows, all under reset register values (radius starts at 0.5,
  // thickness 1.0, blue). The pinned pixels sit far outside the ring, so their
  // result is plain dimming and can be written down directly.
  // ---------------------------------------------------------------------------
  directed_row_t directed_rows [20] = '{
    '{1'b1, '{FUNC_PIXEL,   4'd0,  4'd0,  8'd255, 8'd255, 8'd255, 1'b0},
            '{8'd0,   8'd225, 8'd225, 8'd225, 1'b0, 1'b0}},
    '{1'b1, '{FUNC_PIXEL,   4'd15, 4'd1,  8'd0,   8'd0,   8'd0,   1'b0},
            '{8'd16,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0}},
    '{1'b1, '{FUNC_PIXEL,   4'd0,  4'd15, 8'd1,   8'd128, 8'd254, 1'b0},
            '{8'd255, 8'd0,   8'd112, 8'd224, 1'b0, 1'b0}},
    '{1'b1, '{FUNC_PIXEL,   4'd15, 4'd15, 8'd255, 8'd0,   8'd255, 1'b0},
            '{8'd240, 8'd225, 8'd0,   8'd225, 1'b0, 1'b0}},
    '{1'b0, '{FUNC_PIXEL,   4'd7,  4'd7,  8'd40,  8'd200, 8'd90,  1'b0}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd8,  4'd8,  8'd255, 8'd255, 8'd255, 1'b0}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd8,  4'd7,  8'd0,   8'd0,   8'd0,   1'b1}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd6,  4'd7,  8'd17,  8'd34,  8'd51,  1'b0}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd9,  4'd9,  8'd255, 8'd0,   8'd0,   1'b1}, '0},
    '{1'b0, '{FUNC_RESTART, 4'd5,  4'd5,  8'd255, 8'd255, 8'd255, 1'b1}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd7,  4'd8,  8'd0,   8'd255, 8'd0,   1'b1}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd0,  4'd7,  8'd255, 8'd255, 8'd255, 1'b0}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd15, 4'd8,  8'd3,   8'd4,   8'd5,   1'b1}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd4,  4'd4,  8'd128, 8'd64,  8'd32,  1'b0}, '0},
    '{1'b1, '{FUNC_PIXEL,   4'd0,  4'd0,  8'd0,   8'd0,   8'd0,   1'b0},
            '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0}},
    '{1'b0, '{FUNC_PIXEL,   4'd15, 4'd14, 8'd128, 8'd128, 8'd128, 1'b1}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd3,  4'd12, 8'd200, 8'd100, 8'd50,  1'b0}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd7,  4'd6,  8'd255, 8'd0,   8'd0,   1'b1}, '0},
    '{1'b0, '{FUNC_RESTART, 4'd10, 4'd3,  8'd0,   8'd0,   8'd0,   1'b0}, '0},
    '{1'b0, '{FUNC_PIXEL,   4'd8,  4'd9,  8'd1,   8'd2,   8'd3,   1'b1}, '0}
  };

  // Settings walked after the reset phase; all but the hue select show both
  // extremes, and color modes cover blue, red and purple through the modulo.
  ring_setting_t fixed_settings [N_FIXED] = '{
    '{12'd4095, 10'd1023, 8'd255, 8'd1,   16'd65535},
    '{12'd0,    10'd0,    8'd0,   8'd2,   16'd0},
    '{12'd384,  10'd200,  8'd128, 8'd5,   16'd3},
    '{12'd1024, 10'd512,  8'd77,  8'd255, 16'd10},
    '{12'd300,  10'd64,   8'd255, 8'd254, 16'd2},
    '{12'd2048, 10'd1,    8'd200, 8'd3,   16'd1}
  };

  // ---------------------------------------------------------------------------
  // Output side: stall on a pattern of its own, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_backpressure
    int stretch;
    int stall_pct;
    forever begin
      if (hold_off_request) begin
        // hold the output long enough for the block to back up into its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end else begin
        stretch = $urandom_range(5, 60);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        for (int i = 0; i < stretch && !hold_off_request; i++) begin
          out_stall <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Compare every result beat against the oldest outstanding expectation.
  always @(posedge clk) begin
    led_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (led_expect_q.size() == 0) begin
        flag_mismatch("result with nothing expected, led_index", int'(led_index), -1);
      end else begin
        want = led_expect_q.pop_front();
        if (led_index !== want.led_index)
          flag_mismatch("led_index", int'(led_index), int'(want.led_index));
        if (new_red !== want.red)
          flag_mismatch("new_red", int'(new_red), int'(want.red));
        if (new_green !== want.green)
          flag_mismatch("new_green", int'(new_green), int'(want.green));
        if (new_blue !== want.blue)
          flag_mismatch("new_blue", int'(new_blue), int'(want.blue));
        if (last_of_frame !== want.last)
          flag_mismatch("last_of_frame", int'(last_of_frame), int'(want.last));
        if (anim_done !== want.done)
          flag_mismatch("anim_done", int'(anim_done), int'(want.done));
        if (want.done) done_seen++;
      end
      results_seen++;
    end
  end

  // Watchdog: any handshake on any channel resets the count.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, led_expect_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    ring_setting_t s;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows first, under reset register values
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].want);
    random_frames(BEATS_PER_PHASE);

    // then fixed settings followed by two random ones; registers only change
    // once the block has gone quiet
    for (int p = 0; p < N_FIXED + 2; p++) begin
      settle_pipeline();
      if (p < N_FIXED) s = fixed_settings[p];
      else s = random_setting();
      program_regs(s);
      if (p == 2) hold_off_request = 1'b1;
      random_frames(BEATS_PER_PHASE);
    end

    settle_pipeline();
    $display("covered %0d pixel beats, %0d restarts, %0d register writes in %0d settings",
             pixel_beats, restart_beats, reg_writes, settings_used);
    $display("checked %0d results: %0d ring pixels, %0d with the fade-done flag",
             results_seen, ring_hits, done_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: expanding_ring_led_effect.f
src/erl_pkg.sv
src/erl_cfg.sv
src/erl_anim.sv
src/erl_pixel.sv
src/expanding_ring_led_effect.sv
tb/tb_top.sv
